// File: hdl/world_to_screen_projection_core_defines.svh
// ---------------------------------------------------------------------------
// World-to-screen projection assertion macros
// Shared clocked assertion forms for the projection core.
// ---------------------------------------------------------------------------
`ifndef WORLD_TO_SCREEN_PROJECTION_CORE_DEFINES_SVH
`define WORLD_TO_SCREEN_PROJECTION_CORE_DEFINES_SVH

// same-cycle implication
`define WTSP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define WTSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/wtsp_pkg.sv
// ---------------------------------------------------------------------------
// World-to-screen projection package
// Widths, codes, stage records and saturation shared by the core.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package wtsp_pkg;

  localparam int COEF_COUNT = 12;
  localparam int COEF_IDX_W = 4;
  localparam int QW         = 48;
  localparam int DEN_W      = 31;
  localparam int REM_W      = 32;
  localparam int DIV_BITS   = 4;
  localparam int DIV_STAGES = QW / DIV_BITS;
  localparam int CFG_IDX_W  = 2;

  typedef enum logic {
    CMD_LOAD    = 1'b0,
    CMD_PROJECT = 1'b1
  } cmd_e;

  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 2'd1;

  localparam logic [QW-1:0] NORM_LIMIT = 48'd70368744177664;

  typedef logic [COEF_COUNT-1:0][31:0] coef_arr_t;

  typedef struct packed {
    logic               behind;
    logic signed [31:0] cw;
  } tag_t;

  typedef struct packed {
    logic [QW-1:0]    num_x;
    logic [QW-1:0]    num_y;
    logic             neg_x;
    logic             neg_y;
    logic [DEN_W-1:0] den;
    tag_t             tag;
  } div_in_t;

  typedef struct packed {
    logic [QW-1:0] q_x;
    logic [QW-1:0] q_y;
    logic          neg_x;
    logic          neg_y;
    tag_t          tag;
  } div_out_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// File: hdl/wtsp_if.sv
// ---------------------------------------------------------------------------
// World-to-screen projection channels
// Input and result channels with valid/ready handshake.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface wtsp_in_if;
  import wtsp_pkg::*;
  logic               valid;
  logic               ready;
  cmd_e               command;
  logic [3:0]         coef_index;
  logic signed [31:0] coef_value;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;

  modport source(output valid, command, coef_index, coef_value, point_x, point_y, point_z,
                 input ready);
  modport sink(input valid, command, coef_index, coef_value, point_x, point_y, point_z,
               output ready);
endinterface

interface wtsp_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] screen_x;
  logic signed [31:0] screen_y;
  logic signed [31:0] depth_w;
  logic               behind;

  modport source(output valid, screen_x, screen_y, depth_w, behind, input ready);
  modport sink(input valid, screen_x, screen_y, depth_w, behind, output ready);
endinterface

// File: hdl/wtsp_clip.sv
// ---------------------------------------------------------------------------
// Clip-space transform
// Three stages: nine products, row sums with saturation, divider setup.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module wtsp_clip (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic signed [31:0] x_i,
  input  logic signed [31:0] y_i,
  input  logic signed [31:0] z_i,
  input  wtsp_pkg::coef_arr_t coef_i,
  output logic               valid_o,
  output wtsp_pkg::div_in_t  div_o
);
  import wtsp_pkg::*;

  logic               v1_q, v2_q, v3_q;
  logic signed [63:0] p_q [9];
  logic signed [63:0] p_d [9];
  logic signed [31:0] k_q [3];
  logic signed [31:0] c_q [3];
  logic signed [31:0] c_d [3];
  div_in_t            div_q, div_d;

  always_comb begin
    logic signed [31:0] pt [3];
    pt[0] = x_i;
    pt[1] = y_i;
    pt[2] = z_i;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        p_d[r*3+c] = $signed(coef_i[r*4+c]) * pt[c];
      end
    end
  end

  always_comb begin
    logic signed [63:0] s;
    for (int r = 0; r < 3; r++) begin
      s = (p_q[r*3] >>> 16) + (p_q[r*3+1] >>> 16) + (p_q[r*3+2] >>> 16)
        + $signed({{32{k_q[r][31]}}, k_q[r]});
      c_d[r] = sat32(s);
    end
  end

  always_comb begin
    logic [31:0] mx, my;
    mx = c_q[0][31] ? (~c_q[0] + 32'd1) : c_q[0];
    my = c_q[1][31] ? (~c_q[1] + 32'd1) : c_q[1];
    div_d.num_x      = {mx, 16'd0};
    div_d.num_y      = {my, 16'd0};
    div_d.neg_x      = c_q[0][31];
    div_d.neg_y      = c_q[1][31];
    div_d.den        = c_q[2][DEN_W-1:0];
    div_d.tag.cw     = c_q[2];
    div_d.tag.behind = c_q[2][31] || (c_q[2] == 32'sd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 9; i++) p_q[i] <= p_d[i];
      for (int r = 0; r < 3; r++) begin
        k_q[r] <= $signed(coef_i[r*4+3]);
        c_q[r] <= c_d[r];
      end
      div_q <= div_d;
    end
  end

  assign valid_o = v3_q;
  assign div_o   = div_q;

endmodule

// File: hdl/wtsp_div.sv
// ---------------------------------------------------------------------------
// Pipelined divider
// Two restoring dividers sharing one divisor, a fixed number of bits per stage.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module wtsp_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  wtsp_pkg::div_in_t  div_i,
  output logic               valid_o,
  output wtsp_pkg::div_out_t div_o
);
  import wtsp_pkg::*;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [QW-1:0]    nq;
  } lane_t;

  typedef struct packed {
    lane_t            lx;
    lane_t            ly;
    logic             neg_x;
    logic             neg_y;
    logic [DEN_W-1:0] den;
    tag_t             tag;
  } stage_t;

  function automatic lane_t step(input lane_t l, input logic [DEN_W-1:0] den);
    lane_t          o;
    logic [REM_W:0] r;
    o = l;
    for (int i = 0; i < DIV_BITS; i++) begin
      r    = {o.rem, o.nq[QW-1]};
      o.nq = {o.nq[QW-2:0], 1'b0};
      if (r >= {2'b00, den}) begin
        r       = r - {2'b00, den};
        o.nq[0] = 1'b1;
      end
      o.rem = r[REM_W-1:0];
    end
    return o;
  endfunction

  logic   v_q   [DIV_STAGES];
  stage_t stg_q [DIV_STAGES];
  stage_t stg_d [DIV_STAGES];

  always_comb begin
    stage_t src;
    for (int k = 0; k < DIV_STAGES; k++) begin
      if (k == 0) begin
        src.lx.rem = '0;
        src.lx.nq  = div_i.num_x;
        src.ly.rem = '0;
        src.ly.nq  = div_i.num_y;
        src.neg_x  = div_i.neg_x;
        src.neg_y  = div_i.neg_y;
        src.den    = div_i.den;
        src.tag    = div_i.tag;
      end else begin
        src = stg_q[k-1];
      end
      stg_d[k]    = src;
      stg_d[k].lx = step(src.lx, src.den);
      stg_d[k].ly = step(src.ly, src.den);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DIV_STAGES; k++) v_q[k] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
      for (int k = 1; k < DIV_STAGES; k++) v_q[k] <= v_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < DIV_STAGES; k++) stg_q[k] <= stg_d[k];
    end
  end

  assign valid_o     = v_q[DIV_STAGES-1];
  assign div_o.q_x   = stg_q[DIV_STAGES-1].lx.nq;
  assign div_o.q_y   = stg_q[DIV_STAGES-1].ly.nq;
  assign div_o.neg_x = stg_q[DIV_STAGES-1].neg_x;
  assign div_o.neg_y = stg_q[DIV_STAGES-1].neg_y;
  assign div_o.tag   = stg_q[DIV_STAGES-1].tag;

endmodule

// File: hdl/wtsp_viewport.sv
// ---------------------------------------------------------------------------
// Viewport mapping
// Clamp and scale by the viewport size, then bias, halve and saturate.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module wtsp_viewport (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  wtsp_pkg::div_out_t div_i,
  input  logic [15:0]        width_i,
  input  logic [15:0]        height_i,
  output logic               valid_o,
  output logic signed [31:0] screen_x_o,
  output logic signed [31:0] screen_y_o,
  output logic signed [31:0] depth_w_o,
  output logic               behind_o
);
  import wtsp_pkg::*;

  logic               va_q, vb_q;
  logic signed [63:0] px_q, py_q, px_d, py_d;
  tag_t               tag_q;
  logic signed [31:0] sx_q, sy_q, dw_q, sx_d, sy_d, dw_d;
  logic               bh_q;

  always_comb begin
    logic [QW-1:0]      mx, my;
    logic signed [63:0] nx, ny;
    mx = (div_i.q_x > NORM_LIMIT) ? NORM_LIMIT : div_i.q_x;
    my = (div_i.q_y > NORM_LIMIT) ? NORM_LIMIT : div_i.q_y;
    nx = $signed({16'd0, mx});
    ny = $signed({16'd0, my});
    if (div_i.neg_x) nx = -nx;
    if (div_i.neg_y) ny = -ny;
    px_d = nx * $signed({48'd0, width_i});
    py_d = ny * $signed({48'd0, height_i});
  end

  always_comb begin
    logic signed [63:0] sx, sy;
    sx = ($signed({32'd0, width_i, 16'd0}) + px_q + 64'sd65536) >>> 1;
    sy = ($signed({32'd0, height_i, 16'd0}) - py_q - 64'sd65536) >>> 1;
    if (tag_q.behind) begin
      sx_d = '0;
      sy_d = '0;
      dw_d = '0;
    end else begin
      sx_d = sat32(sx);
      sy_d = sat32(sy);
      dw_d = tag_q.cw;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      px_q  <= px_d;
      py_q  <= py_d;
      tag_q <= div_i.tag;
      sx_q  <= sx_d;
      sy_q  <= sy_d;
      dw_q  <= dw_d;
      bh_q  <= tag_q.behind;
    end
  end

  assign valid_o    = vb_q;
  assign screen_x_o = sx_q;
  assign screen_y_o = sy_q;
  assign depth_w_o  = dw_q;
  assign behind_o   = bh_q;

endmodule

// File: hdl/world_to_screen_projection_core.sv
// Pipeline: 3 clip stages, 12 divider stages at 4 quotient bits each and 2 viewport
//   stages lie between an accepted project item and its result.
// Throughput: one item per cycle; the whole pipeline holds while the result waits.
// Load items update the coefficient store at acceptance and produce no result.
// Reset clears the coefficient store and pipeline valids and sets the viewport
//   to 1920 by 1080.
// ---------------------------------------------------------------------------
// World-to-screen projection core
// Coefficient store, clip transform, pipelined divide and viewport mapping.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "world_to_screen_projection_core_defines.svh"

module world_to_screen_projection_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  wtsp_in_if.sink                        in_i,
  wtsp_out_if.source                     out_o,
  input  logic                           cfg_we_i,
  input  logic [wtsp_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [15:0]                    cfg_data_i
);
  import wtsp_pkg::*;

  logic      en;
  logic      load_acc;
  logic      proj_valid;
  coef_arr_t coef_q;
  logic [15:0] width_q, height_q;
  logic      clip_valid, div_valid;
  div_in_t   clip_out;
  div_out_t  div_out;

  assign en         = !out_o.valid || out_o.ready;
  assign in_i.ready = en;
  assign load_acc   = in_i.valid && en && (in_i.command == CMD_LOAD);
  assign proj_valid = in_i.valid && (in_i.command == CMD_PROJECT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '0;
    end else if (load_acc && (in_i.coef_index < COEF_IDX_W'(COEF_COUNT))) begin
      coef_q[in_i.coef_index] <= in_i.coef_value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 16'd1920;
      height_q <= 16'd1080;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SCREEN_WIDTH:  width_q  <= cfg_data_i;
        CFG_SCREEN_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  wtsp_clip u_clip (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (proj_valid),
    .x_i     (in_i.point_x),
    .y_i     (in_i.point_y),
    .z_i     (in_i.point_z),
    .coef_i  (coef_q),
    .valid_o (clip_valid),
    .div_o   (clip_out)
  );

  wtsp_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (clip_valid),
    .div_i   (clip_out),
    .valid_o (div_valid),
    .div_o   (div_out)
  );

  wtsp_viewport u_viewport (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (div_valid),
    .div_i      (div_out),
    .width_i    (width_q),
    .height_i   (height_q),
    .valid_o    (out_o.valid),
    .screen_x_o (out_o.screen_x),
    .screen_y_o (out_o.screen_y),
    .depth_w_o  (out_o.depth_w),
    .behind_o   (out_o.behind)
  );

  `WTSP_ASSERT_NOW(a_behind_zero, out_o.valid && out_o.behind, (out_o.screen_x == 32'sd0) && (out_o.screen_y == 32'sd0) && (out_o.depth_w == 32'sd0), "behind item with nonzero fields")
  `WTSP_ASSERT_NOW(a_front_depth, out_o.valid && !out_o.behind, out_o.depth_w > 32'sd0, "front item with nonpositive depth")
  `WTSP_ASSERT_NEXT(a_load_slot0, load_acc && (in_i.coef_index == 4'd0), coef_q[0] == $past(in_i.coef_value), "coefficient load lost")

endmodule
